// ===== rtl/thick_line_quad_expand_top_macros.svh =====
// Assertion macros shared by the checker of the thick line expander.
`ifndef THICK_LINE_QUAD_EXPAND_TOP_MACROS_SVH
`define THICK_LINE_QUAD_EXPAND_TOP_MACROS_SVH

// Checked only while reset is released.
`define TLQE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TLQE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tlqe_pkg.sv =====
// Shared constants and types of the thick line expander.
package tlqe_pkg;

	localparam int COORD_FRAC_BITS = 16;
	localparam int SCALE_SHIFT     = 40 - COORD_FRAC_BITS;
	localparam logic [79:0] ROUND_HALF = 80'(1) << (39 - COORD_FRAC_BITS);
	localparam logic [32:0] OFFSET_CAP = 33'h1_0000_0000;

	localparam int SQRT_STEPS     = 32;
	localparam int SQRT_PER_STAGE = 2;
	localparam int SQRT_STAGES    = SQRT_STEPS / SQRT_PER_STAGE;

	localparam int DIV_STEPS     = 63;
	localparam int DIV_PER_STAGE = 2;
	localparam int DIV_STAGES    = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

	localparam int MID_STAGES = SQRT_STAGES + DIV_STAGES;

	localparam logic       REG_DRAW_EN = 1'b0;
	localparam logic [2:0] VTX_LAST    = 3'd5;

	typedef struct packed {
		logic               func;
		logic               horiz;
		logic               neg;
		logic signed [31:0] p1x;
		logic signed [31:0] p1y;
		logic signed [31:0] p2x;
		logic signed [31:0] p2y;
		logic [15:0]        thickness;
		logic [31:0]        color;
	} seg_t;

	function automatic logic [4:0] lzc31(input logic [30:0] v);
		logic [4:0] n;
		n = 5'd0;
		for (int i = 0; i < 31; i++) begin
			if (v[i]) n = 5'(30 - i);
		end
		return n;
	endfunction

endpackage

// ===== rtl/tlqe_sqrt.sv =====
// Pipelined integer square root, two result bits per stage.
module tlqe_sqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] radicand,
	output logic [31:0] root
);

	logic [63:0] rem_q [tlqe_pkg::SQRT_STAGES];
	logic [63:0] res_q [tlqe_pkg::SQRT_STAGES];

	for (genvar g = 0; g < tlqe_pkg::SQRT_STAGES; g++) begin : g_stage
		logic [63:0] rem_i, res_i, rem_o, res_o;

		if (g == 0) begin : g_first
			assign rem_i = radicand;
			assign res_i = '0;
		end else begin : g_next
			assign rem_i = rem_q[g-1];
			assign res_i = res_q[g-1];
		end

		always_comb begin
			logic [63:0] bitv, trial;
			rem_o = rem_i;
			res_o = res_i;
			for (int j = 0; j < tlqe_pkg::SQRT_PER_STAGE; j++) begin
				bitv  = 64'(1) << (62 - 2 * (g * tlqe_pkg::SQRT_PER_STAGE + j));
				trial = res_o + bitv;
				if (rem_o >= trial) begin
					rem_o = rem_o - trial;
					res_o = (res_o >> 1) + bitv;
				end else begin
					res_o = res_o >> 1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[g] <= rem_o;
				res_q[g] <= res_o;
			end
		end
	end

	assign root = res_q[tlqe_pkg::SQRT_STAGES-1][31:0];

endmodule

// ===== rtl/tlqe_div.sv =====
// Pipelined restoring divider: (dividend << 31) / divisor, two quotient bits per stage.
module tlqe_div (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic [62:0] quotient
);

	logic [31:0] num_q [tlqe_pkg::DIV_STAGES];
	logic [31:0] den_q [tlqe_pkg::DIV_STAGES];
	logic [31:0] rem_q [tlqe_pkg::DIV_STAGES];
	logic [62:0] quo_q [tlqe_pkg::DIV_STAGES];

	for (genvar g = 0; g < tlqe_pkg::DIV_STAGES; g++) begin : g_stage
		logic [31:0] num_i, den_i, rem_i, num_o, rem_o;
		logic [62:0] quo_i, quo_o;

		if (g == 0) begin : g_first
			assign num_i = dividend;
			assign den_i = divisor;
			assign rem_i = '0;
			assign quo_i = '0;
		end else begin : g_next
			assign num_i = num_q[g-1];
			assign den_i = den_q[g-1];
			assign rem_i = rem_q[g-1];
			assign quo_i = quo_q[g-1];
		end

		// The dividend bits come first, then the 31 zero bits of the shift.
		always_comb begin
			logic [32:0] part;
			logic        qb;
			num_o = num_i;
			rem_o = rem_i;
			quo_o = quo_i;
			for (int j = 0; j < tlqe_pkg::DIV_PER_STAGE; j++) begin
				if (g * tlqe_pkg::DIV_PER_STAGE + j < tlqe_pkg::DIV_STEPS) begin
					part  = {rem_o, num_o[31]};
					num_o = num_o << 1;
					qb    = 1'b0;
					if (part >= {1'b0, den_i}) begin
						part = part - {1'b0, den_i};
						qb   = 1'b1;
					end
					rem_o = part[31:0];
					quo_o = {quo_o[61:0], qb};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_q[g] <= num_o;
				den_q[g] <= den_i;
				rem_q[g] <= rem_o;
				quo_q[g] <= quo_o;
			end
		end
	end

	assign quotient = quo_q[tlqe_pkg::DIV_STAGES-1];

endmodule

// ===== rtl/thick_line_quad_expand_top.sv =====
// Top level of the thick line to triangle pair expander.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------------
//  in      | request   | in_valid / in_stall     | func, start/end x y, thickness, color
//  out     | vertex    | out_valid / out_stall   | vertex_x, vertex_y, vertex_color, last
//  config  | APB write | psel penable pwrite     | paddr, pwdata (drawing_enabled)
//
// A request that draws yields six vertices, and the vertex stage holds it until all six
// have gone out; only then can the next request enter the vertex stage.
// Path: stages 1 to 4, square root, dividers, stages 5 and 6, vertex stage, output register.
// An output stall holds the vertex stage; the pipeline keeps moving until a request
// waits in its last stage, and only then does in_stall rise. Nothing is dropped or repeated.
// Reset clears all valid bits and drawing_enabled.
module thick_line_quad_expand_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [31:0] end_x,
	input  logic signed [31:0] end_y,
	input  logic [15:0]        thickness,
	input  logic [31:0]        fill_color,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] vertex_x,
	output logic signed [31:0] vertex_y,
	output logic [31:0]        vertex_color,
	output logic               last
);

	localparam int SQ  = tlqe_pkg::SQRT_STAGES;
	localparam int MID = tlqe_pkg::MID_STAGES;

	function automatic logic [32:0] scale_off(input logic [46:0] hi, input logic [47:0] lo);
		logic [79:0] sum;
		logic [63:0] v;
		sum = (80'(hi) << 32) + 80'(lo) + tlqe_pkg::ROUND_HALF;
		v   = sum[63:0] >> tlqe_pkg::SCALE_SHIFT;
		if (sum[79:64] != '0) return tlqe_pkg::OFFSET_CAP;
		if (v > 64'(tlqe_pkg::OFFSET_CAP)) return tlqe_pkg::OFFSET_CAP;
		return v[32:0];
	endfunction

	function automatic logic [31:0] sat32(input logic signed [34:0] v);
		if (v > 35'sd2147483647) return 32'h7fff_ffff;
		if (v < -35'sd2147483648) return 32'h8000_0000;
		return v[31:0];
	endfunction

	// Configuration.
	logic draw_en_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == tlqe_pkg::REG_DRAW_EN) ? {31'b0, draw_en_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_en_q <= 1'b0;
		end else if (cfg_wr && paddr[2] == tlqe_pkg::REG_DRAW_EN) begin
			draw_en_q <= pwdata[0];
		end
	end

	logic adv;
	assign in_stall = !adv;

	// Stage 1: differences, magnitudes and endpoint order.
	logic signed [32:0] dx, dy;
	logic               horiz, swap;
	tlqe_pkg::seg_t     seg_in;
	logic               v_s1;
	tlqe_pkg::seg_t     seg_s1;
	logic [32:0]        adx_s1, ady_s1;

	always_comb begin
		dx     = 33'(end_x) - 33'(start_x);
		dy     = 33'(start_y) - 33'(end_y);
		horiz  = (dy == '0);
		swap   = horiz ? (end_x < start_x) : (start_y < end_y);
		seg_in.func      = func;
		seg_in.horiz     = horiz;
		seg_in.neg       = !horiz && (dx[32] != dy[32]) && (dx != '0);
		seg_in.p1x       = swap ? end_x : start_x;
		seg_in.p1y       = swap ? end_y : start_y;
		seg_in.p2x       = swap ? start_x : end_x;
		seg_in.p2y       = swap ? start_y : end_y;
		seg_in.thickness = thickness;
		seg_in.color     = fill_color;
	end

	// Stage 2: normalization shift. Stage 3: normalized magnitudes. Stage 4: squares.
	logic           v_s2, v_s3, v_s4;
	tlqe_pkg::seg_t seg_s2, seg_s3, seg_s4;
	logic [32:0]    adx_s2, ady_s2, m1;
	logic           halve_s2;
	logic [4:0]     sh_s2;
	logic [31:0]    ax_s3, ay_s3, ax_s4, ay_s4;
	logic [33:0]    rx_up, ry_up;
	logic [63:0]    sqx_s4, sqy_s4;

	assign m1    = (adx_s1 >= ady_s1) ? adx_s1 : ady_s1;
	assign rx_up = 34'(adx_s2) + 34'd1;
	assign ry_up = 34'(ady_s2) + 34'd1;

	// Middle section: square root then the two dividers.
	logic           v_mid_q   [MID];
	tlqe_pkg::seg_t seg_mid_q [MID];
	logic [31:0]    ax_mid_q  [SQ];
	logic [31:0]    ay_mid_q  [SQ];
	logic [31:0]    len;
	logic [31:0]    num_a, den_a;
	logic [62:0]    quo_a, quo_b;
	tlqe_pkg::seg_t seg_sq;

	tlqe_sqrt u_sqrt (
		.clk      (clk),
		.en       (adv),
		.radicand (sqx_s4 + sqy_s4),
		.root     (len)
	);

	assign seg_sq = seg_mid_q[SQ-1];
	assign num_a  = seg_sq.func ? len : ay_mid_q[SQ-1];
	assign den_a  = seg_sq.func ? ay_mid_q[SQ-1] : len;

	tlqe_div u_div_a (
		.clk      (clk),
		.en       (adv),
		.dividend (num_a),
		.divisor  (den_a),
		.quotient (quo_a)
	);

	tlqe_div u_div_b (
		.clk      (clk),
		.en       (adv),
		.dividend (ax_mid_q[SQ-1]),
		.divisor  (len),
		.quotient (quo_b)
	);

	// Stage 5: partial products of width times ratio. Stage 6: rounded offsets.
	tlqe_pkg::seg_t seg_dv;
	logic [62:0]    rx, ry;
	logic           v_s5, v_s6;
	tlqe_pkg::seg_t seg_s5, seg_s6;
	logic [47:0]    pxl_s5, pyl_s5;
	logic [46:0]    pxh_s5, pyh_s5;
	logic [32:0]    ox_s6, oy_s6;

	assign seg_dv = seg_mid_q[MID-1];
	assign rx = seg_dv.horiz ? '0 : quo_a;
	assign ry = seg_dv.horiz ? (63'(1) << 31) : (seg_dv.func ? '0 : quo_b);

	// Vertex stage: one item held while its six vertices go out.
	logic           emit_v_q, emit_free, out_load;
	logic [2:0]     cnt_q;
	tlqe_pkg::seg_t item_q;
	logic [32:0]    ox_q, oy_q;
	logic           out_valid_q;
	logic [31:0]    vx_q, vy_q, vc_q;
	logic           last_q;

	assign out_load  = !out_valid_q || !out_stall;
	assign emit_free = !emit_v_q || (out_load && cnt_q == tlqe_pkg::VTX_LAST);
	assign adv       = !v_s6 || emit_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			for (int i = 0; i < MID; i++) v_mid_q[i] <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid && draw_en_q && !(func && horiz);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_mid_q[0] <= v_s4;
			for (int i = 1; i < MID; i++) v_mid_q[i] <= v_mid_q[i-1];
			v_s5 <= v_mid_q[MID-1];
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			seg_s1   <= seg_in;
			adx_s1   <= dx[32] ? 33'(-dx) : 33'(dx);
			ady_s1   <= dy[32] ? 33'(-dy) : 33'(dy);
			seg_s2   <= seg_s1;
			adx_s2   <= adx_s1;
			ady_s2   <= ady_s1;
			halve_s2 <= m1[32] || m1[31];
			sh_s2    <= tlqe_pkg::lzc31(m1[30:0]);
			seg_s3   <= seg_s2;
			ax_s3    <= halve_s2 ? rx_up[32:1] : (adx_s2[31:0] << sh_s2);
			ay_s3    <= halve_s2 ? ry_up[32:1] : (ady_s2[31:0] << sh_s2);
			seg_s4   <= seg_s3;
			ax_s4    <= ax_s3;
			ay_s4    <= ay_s3;
			sqx_s4   <= 64'(ax_s3) * 64'(ax_s3);
			sqy_s4   <= 64'(ay_s3) * 64'(ay_s3);
			seg_mid_q[0] <= seg_s4;
			for (int i = 1; i < MID; i++) seg_mid_q[i] <= seg_mid_q[i-1];
			ax_mid_q[0] <= ax_s4;
			ay_mid_q[0] <= ay_s4;
			for (int i = 1; i < SQ; i++) begin
				ax_mid_q[i] <= ax_mid_q[i-1];
				ay_mid_q[i] <= ay_mid_q[i-1];
			end
			seg_s5 <= seg_dv;
			pxl_s5 <= 48'(seg_dv.thickness) * 48'(rx[31:0]);
			pxh_s5 <= 47'(seg_dv.thickness) * 47'(rx[62:32]);
			pyl_s5 <= 48'(seg_dv.thickness) * 48'(ry[31:0]);
			pyh_s5 <= 47'(seg_dv.thickness) * 47'(ry[62:32]);
			seg_s6 <= seg_s5;
			ox_s6  <= scale_off(pxh_s5, pxl_s5);
			oy_s6  <= scale_off(pyh_s5, pyl_s5);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_v_q <= 1'b0;
			cnt_q    <= '0;
		end else if (emit_free) begin
			emit_v_q <= v_s6;
			cnt_q    <= '0;
		end else if (out_load) begin
			cnt_q <= cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_free) begin
			item_q <= seg_s6;
			ox_q   <= ox_s6;
			oy_q   <= oy_s6;
		end
	end

	// Corner order: P1-o, P2-o, P1+o, P2+o, P1+o, P2-o.
	logic               minus, ymin;
	logic signed [34:0] ox_e, oy_e, vx_sum, vy_sum;

	always_comb begin
		minus  = (cnt_q == 3'd0) || (cnt_q == 3'd1) || (cnt_q == tlqe_pkg::VTX_LAST);
		ymin   = minus ^ item_q.neg;
		ox_e   = signed'(35'(ox_q));
		oy_e   = signed'(35'(oy_q));
		vx_sum = 35'(cnt_q[0] ? item_q.p2x : item_q.p1x) + (minus ? -ox_e : ox_e);
		vy_sum = 35'(cnt_q[0] ? item_q.p2y : item_q.p1y) + (ymin ? -oy_e : oy_e);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= emit_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && emit_v_q) begin
			vx_q   <= sat32(vx_sum);
			vy_q   <= sat32(vy_sum);
			vc_q   <= item_q.color;
			last_q <= (cnt_q == tlqe_pkg::VTX_LAST);
		end
	end

	assign out_valid    = out_valid_q;
	assign vertex_x     = vx_q;
	assign vertex_y     = vy_q;
	assign vertex_color = vc_q;
	assign last         = last_q;

endmodule

// ===== rtl/tlqe_checker.sv =====
// Port-level checker for the thick line expander, bound to its top level.
`include "thick_line_quad_expand_top_macros.svh"

module tlqe_assertions (
	input logic               clk,
	input logic               arst_n,
	input logic               psel,
	input logic               penable,
	input logic               pwrite,
	input logic [2:0]         paddr,
	input logic [31:0]        pwdata,
	input logic [31:0]        prdata,
	input logic               pready,
	input logic               in_valid,
	input logic               in_stall,
	input logic               func,
	input logic signed [31:0] start_x,
	input logic signed [31:0] start_y,
	input logic signed [31:0] end_x,
	input logic signed [31:0] end_y,
	input logic [15:0]        thickness,
	input logic [31:0]        fill_color,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] vertex_x,
	input logic signed [31:0] vertex_y,
	input logic [31:0]        vertex_color,
	input logic               last
);

	property p_out_hold;
		out_valid && out_stall |=>
			out_valid && $stable(vertex_x) && $stable(vertex_y) && $stable(last);
	endproperty

	property p_burst;
		out_valid && !out_stall && !last |=>
			out_valid && vertex_color == $past(vertex_color);
	endproperty

	// Reset clears the output valid.
	`TLQE_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !out_valid, "vertex shown during reset")

	`TLQE_ASSERT(a_out_hold, p_out_hold, "stalled vertex changed")

	// The six vertices of one segment leave back to back with one color.
	`TLQE_ASSERT(a_burst, p_burst, "vertex burst broken")

	`TLQE_ASSERT(a_last_single, out_valid && !out_stall && last |=> !(out_valid && last), "two last vertices in a row")

endmodule

bind thick_line_quad_expand_top tlqe_assertions u_tlqe_checker (.*);
